// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the RTL folder, lms3_checker.
// Depends on a clk and an active-high synchronous rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LMS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("local maxima check failed");

// Condition must never be seen at a clock edge outside reset.
`define LMS_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("local maxima forbidden condition seen");

`endif

// ----- hw/rtl/lms3_pkg.sv -----
// Constants of the 3x3 local maximum sum block: field widths and register map.
// No dependencies.
package lms3_pkg;

  localparam int SUM_BITS    = 48;
  localparam int COUNT_BITS  = 25;
  localparam int ROW_BITS    = 16;
  localparam int COLCFG_BITS = 10;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 3;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

endpackage

// ----- hw/rtl/local_maxima_sum_3x3.sv -----
// Top level of the 3x3 strict local maximum sum block.
// Depends on lms3_pkg.

// Takes one sample per clock cycle in raster order, sustained across rows and
// frames, and marks each sample that is strictly greater than all of its
// in-frame 3x3 neighbours. Two line stores of MAX_COLUMNS samples, each one
// synchronous memory read and written once per sample, feed the window; a
// write hitting the entry that the next sample reads is forwarded. The last
// row is judged while it streams in, so no sweep follows the frame. The
// frame's sum and count pass the s1 and s2 stages and leave through an output
// register. Input is held off only while a finished frame result waits in the
// output register and the next frame's result is ready behind it. Register
// writes restart the frame.
module local_maxima_sum_3x3
  import lms3_pkg::*;
#(
  parameter int MAX_COLUMNS = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SUM_BITS-1:0]    maxima_sum,
  output logic [COUNT_BITS-1:0]         maxima_count
);

  localparam int AW = $clog2(MAX_COLUMNS);
  localparam int NW = $clog2(MAX_COLUMNS + 1);
  localparam int EW = (NW > COLCFG_BITS) ? NW : COLCFG_BITS;
  localparam int SB = SAMPLE_BITS;

  typedef struct packed {
    logic rge1;
    logic rge2;
    logic cge1;
    logic cge2;
    logic clast;
    logic rlast;
  } pos_flags_t;

  function automatic logic [AW-1:0] last_col(input logic [COLCFG_BITS-1:0] v);
    logic [EW-1:0] ext;
    ext = EW'(v);
    if (ext == '0) begin
      return '0;
    end else if (ext > EW'(MAX_COLUMNS)) begin
      return AW'(MAX_COLUMNS - 1);
    end else begin
      return AW'(ext - EW'(1));
    end
  endfunction

  function automatic logic beats(input logic signed [SB-1:0] c,
                                 input logic signed [SB-1:0] n,
                                 input logic en);
    return !en || (c > n);
  endfunction

  // configuration
  logic [ROW_BITS-1:0]    row_count;
  logic [COLCFG_BITS-1:0] col_count;
  logic [ROW_BITS-1:0]    row_last;
  logic [AW-1:0]          col_last;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_BITS'(1);
      col_count <= COLCFG_BITS'(512);
      row_last  <= '0;
      col_last  <= last_col(COLCFG_BITS'(512));
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_COUNT: begin
          row_count <= pwdata[ROW_BITS-1:0];
          row_last  <= (pwdata[ROW_BITS-1:0] == '0) ? '0 :
                       pwdata[ROW_BITS-1:0] - ROW_BITS'(1);
        end
        REG_COL_COUNT: begin
          col_count <= pwdata[COLCFG_BITS-1:0];
          col_last  <= last_col(pwdata[COLCFG_BITS-1:0]);
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_COUNT: prdata = {{(DATA_BITS-ROW_BITS){1'b0}}, row_count};
      REG_COL_COUNT: prdata = {{(DATA_BITS-COLCFG_BITS){1'b0}}, col_count};
    endcase
  end

  // handshake and pipeline control
  logic stall;
  logic advance;
  logic accept;
  logic s1_valid;
  logic s2_valid;
  logic s2_last;

  assign stall    = s2_valid && s2_last && out_valid && !out_ready;
  assign advance  = !stall;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // raster position
  logic [ROW_BITS-1:0] row_pos;
  logic [AW-1:0]       col_pos;
  pos_flags_t          flags_next;

  always_comb begin
    flags_next.rge1  = row_pos != '0;
    flags_next.rge2  = row_pos[ROW_BITS-1:1] != '0;
    flags_next.cge1  = col_pos != '0;
    flags_next.cge2  = col_pos[AW-1:1] != '0;
    flags_next.clast = col_pos == col_last;
    flags_next.rlast = row_pos == row_last;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (flags_next.clast) begin
        col_pos <= '0;
        row_pos <= flags_next.rlast ? '0 : row_pos + ROW_BITS'(1);
      end else begin
        col_pos <= col_pos + AW'(1);
      end
    end
  end

  // line stores
  logic signed [SB-1:0] upper_mem  [MAX_COLUMNS];
  logic signed [SB-1:0] middle_mem [MAX_COLUMNS];
  logic signed [SB-1:0] mem_up_q;
  logic signed [SB-1:0] mem_mid_q;

  logic signed [SB-1:0] s1_sample;
  logic [AW-1:0]        s1_col;
  pos_flags_t           s1_flags;
  logic                 fwd;
  logic signed [SB-1:0] fwd_up;
  logic signed [SB-1:0] fwd_mid;
  logic signed [SB-1:0] up_eff;
  logic signed [SB-1:0] mid_eff;

  assign up_eff  = fwd ? fwd_up  : mem_up_q;
  assign mid_eff = fwd ? fwd_mid : mem_mid_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_up_q  <= upper_mem[col_pos];
      mem_mid_q <= middle_mem[col_pos];
    end
    if (s1_valid && advance) begin
      upper_mem[s1_col]  <= mid_eff;
      middle_mem[s1_col] <= s1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= sample;
      s1_col    <= col_pos;
      s1_flags  <= flags_next;
      fwd       <= s1_valid && (s1_col == col_pos);
      fwd_up    <= mid_eff;
      fwd_mid   <= s1_sample;
    end
  end

  // window: columns 0 and 1 held, column 2 is the current column
  logic signed [SB-1:0] win [3][2];
  logic signed [SB-1:0] w00, w01, w02, w10, w11, w12, w20, w21, w22;

  assign w00 = win[0][0];
  assign w01 = win[0][1];
  assign w02 = up_eff;
  assign w10 = win[1][0];
  assign w11 = win[1][1];
  assign w12 = mid_eff;
  assign w20 = win[2][0];
  assign w21 = win[2][1];
  assign w22 = s1_sample;

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      win[0][0] <= w01;
      win[0][1] <= w02;
      win[1][0] <= w11;
      win[1][1] <= w12;
      win[2][0] <= w21;
      win[2][1] <= w22;
    end
  end

  // judging
  logic [3:0] peak;
  pos_flags_t f;

  assign f = s1_flags;

  always_comb begin
    peak[0] = f.rge1 && f.cge1 &&
              beats(w11, w00, f.rge2 && f.cge2) && beats(w11, w01, f.rge2) &&
              beats(w11, w02, f.rge2) && beats(w11, w10, f.cge2) &&
              beats(w11, w12, 1'b1) && beats(w11, w20, f.cge2) &&
              beats(w11, w21, 1'b1) && beats(w11, w22, 1'b1);
    peak[1] = f.rge1 && f.clast &&
              beats(w12, w01, f.rge2 && f.cge1) && beats(w12, w02, f.rge2) &&
              beats(w12, w11, f.cge1) && beats(w12, w21, f.cge1) &&
              beats(w12, w22, 1'b1);
    peak[2] = f.rlast && f.cge1 &&
              beats(w21, w10, f.rge1 && f.cge2) && beats(w21, w11, f.rge1) &&
              beats(w21, w12, f.rge1) && beats(w21, w20, f.cge2) &&
              beats(w21, w22, 1'b1);
    peak[3] = f.rlast && f.clast &&
              beats(w22, w11, f.rge1 && f.cge1) && beats(w22, w12, f.rge1) &&
              beats(w22, w21, f.cge1);
  end

  logic [3:0]           s2_peak;
  logic signed [SB-1:0] s2_ctr [4];

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_peak   <= peak;
      s2_ctr[0] <= w11;
      s2_ctr[1] <= w12;
      s2_ctr[2] <= w21;
      s2_ctr[3] <= w22;
      s2_last   <= f.rlast && f.clast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // accumulation and result
  logic signed [SUM_BITS-1:0] running_sum;
  logic [COUNT_BITS-1:0]      running_count;
  logic signed [SUM_BITS-1:0] sum_next;
  logic [COUNT_BITS-1:0]      count_next;
  logic                       s2_fire;

  assign s2_fire = s2_valid && advance;

  always_comb begin
    sum_next   = running_sum;
    count_next = running_count + COUNT_BITS'($countones(s2_peak));
    for (int i = 0; i < 4; i++) begin
      if (s2_peak[i]) begin
        sum_next = sum_next + {{(SUM_BITS-SB){s2_ctr[i][SB-1]}}, s2_ctr[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      running_sum   <= '0;
      running_count <= '0;
    end else if (s2_fire) begin
      running_sum   <= s2_last ? '0 : sum_next;
      running_count <= s2_last ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire && s2_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_last) begin
      maxima_sum   <= sum_next;
      maxima_count <= count_next;
    end
  end

endmodule

// ----- hw/rtl/lms3_checker.sv -----
// Port-level checks for local_maxima_sum_3x3, attached by bind.
// Depends on lms3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lms3_checker
  import lms3_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [ADDR_BITS-1:0]          paddr,
  input logic [DATA_BITS-1:0]          pwdata,
  input logic [DATA_BITS-1:0]          prdata,
  input logic                          pready,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SUM_BITS-1:0]    maxima_sum,
  input logic [COUNT_BITS-1:0]         maxima_count
);

  logic wr_row;
  logic rd_row;
  logic wr_col;
  logic rd_col;

  assign wr_row = psel && penable && pwrite && pready && (paddr[2] == REG_ROW_COUNT);
  assign rd_row = psel && !pwrite && (paddr[2] == REG_ROW_COUNT);
  assign wr_col = psel && penable && pwrite && pready && (paddr[2] == REG_COL_COUNT);
  assign rd_col = psel && !pwrite && (paddr[2] == REG_COL_COUNT);

  `LMS_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(maxima_sum) && $stable(maxima_count))
  `LMS_ASSERT_NEVER(a_empty_sum, out_valid && (maxima_count == '0) && (maxima_sum != '0))
  `LMS_ASSERT(a_row_readback, wr_row ##1 rd_row |-> prdata[ROW_BITS-1:0] == $past(pwdata[ROW_BITS-1:0]))
  `LMS_ASSERT(a_col_readback, wr_col ##1 rd_col |-> prdata[COLCFG_BITS-1:0] == $past(pwdata[COLCFG_BITS-1:0]))

endmodule

bind local_maxima_sum_3x3 lms3_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lms3_checker (.*);

// ----- verif/lms3_peak_tracker_pkg.sv -----
// Frame total predictor and scoreboard for the 3x3 strict local maximum sum block.
// Depends on lms3_pkg for the result widths and the register map.
`timescale 1ns / 1ps
package lms3_peak_tracker_pkg;
  import lms3_pkg::*;

  localparam int LINE_DEPTH = 512;
  localparam int PIX_BITS   = 16;

  typedef logic signed [PIX_BITS-1:0] pix_t;
  typedef logic [2:0][2:0][PIX_BITS-1:0] window_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [COUNT_BITS-1:0]      count;
  } frame_total_t;

  class local_peak_tracker;
    logic [ROW_BITS-1:0]    rows_cfg;
    logic [COLCFG_BITS-1:0] cols_cfg;
    pix_t                   line_upper [LINE_DEPTH];
    pix_t                   line_middle [LINE_DEPTH];
    window_t                win;
    int unsigned            row_pos;
    int unsigned            col_pos;
    longint                 peak_sum;
    int unsigned            peak_count;
    frame_total_t           totals_due [$];
    int unsigned            errors;
    int unsigned            totals_seen;

    function new();
      rows_cfg    = 1;
      cols_cfg    = 512;
      errors      = 0;
      totals_seen = 0;
      foreach (line_upper[i]) begin
        line_upper[i]  = '0;
        line_middle[i] = '0;
      end
      restart();
    endfunction

    function void restart();
      win        = '0;
      row_pos    = 0;
      col_pos    = 0;
      peak_sum   = 0;
      peak_count = 0;
    endfunction

    function void set_register(logic idx, logic [DATA_BITS-1:0] value);
      if (idx == REG_ROW_COUNT) begin
        rows_cfg = value[ROW_BITS-1:0];
      end else if (idx == REG_COL_COUNT) begin
        cols_cfg = value[COLCFG_BITS-1:0];
      end
      restart();
    endfunction

    // Add the centre to the running total when it beats every neighbour in the frame.
    function void tally(window_t w, int cr, int cc, bit up, bit down, bit left, bit right);
      pix_t centre;
      bit   peak;
      int   rr;
      int   kk;
      centre = w[cr][cc];
      peak   = 1'b1;
      for (int di = -1; di <= 1; di++) begin
        for (int dj = -1; dj <= 1; dj++) begin
          rr = cr + di;
          kk = cc + dj;
          if ((di == 0 && dj == 0) || (di < 0 && !up) || (di > 0 && !down) ||
              (dj < 0 && !left) || (dj > 0 && !right) ||
              rr < 0 || rr > 2 || kk < 0 || kk > 2) continue;
          if (centre <= pix_t'(w[rr][kk])) peak = 1'b0;
        end
      end
      if (peak) begin
        peak_sum += longint'(centre);
        peak_count++;
      end
    endfunction

    function void take_sample(pix_t s);
      int unsigned m;
      int unsigned n;
      int unsigned r;
      int unsigned c;
      int unsigned col;
      window_t     w;
      m = (rows_cfg == 0) ? 1 : rows_cfg;
      n = (cols_cfg == 0) ? 1 : (cols_cfg > LINE_DEPTH) ? LINE_DEPTH : cols_cfg;
      r = row_pos;
      c = col_pos;
      if (c >= n) c = n - 1;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = line_upper[c];
      win[1][2] = line_middle[c];
      win[2][2] = s;
      if (r >= 1 && c >= 1) tally(win, 1, 1, r >= 2, 1'b1, c >= 2, 1'b1);
      if (r >= 1 && c + 1 == n) tally(win, 1, 2, r >= 2, 1'b1, c >= 1, 1'b0);
      line_upper[c]  = line_middle[c];
      line_middle[c] = s;
      if (c + 1 < n) begin
        col_pos = c + 1;
        return;
      end
      col_pos = 0;
      if (r + 1 < m) begin
        row_pos = r + 1;
        return;
      end
      // judge the last row, which has nothing below it
      for (int j = 0; j < n; j++) begin
        w = '0;
        for (int k = 0; k < 3; k++) begin
          if ((k == 0 && j == 0) || (k == 2 && j + 1 >= n)) continue;
          col = j + k - 1;
          w[0][k] = line_upper[col];
          w[1][k] = line_middle[col];
        end
        tally(w, 1, 1, m >= 2, 1'b0, j >= 1, j + 1 < n);
      end
      totals_due.push_back('{sum: peak_sum[SUM_BITS-1:0], count: peak_count[COUNT_BITS-1:0]});
      restart();
    endfunction

    function void match_total(logic signed [SUM_BITS-1:0] sum, logic [COUNT_BITS-1:0] count);
      frame_total_t due;
      totals_seen++;
      if (totals_due.size() == 0) begin
        errors++;
        $display("%0t: frame total with none due: sum %0d count %0d", $time, sum, count);
        return;
      end
      due = totals_due.pop_front();
      if (sum !== due.sum) begin
        errors++;
        $display("%0t: maxima_sum expected %0d actual %0d", $time, $signed(due.sum), sum);
      end
      if (count !== due.count) begin
        errors++;
        $display("%0t: maxima_count expected %0d actual %0d", $time, due.count, count);
      end
    endfunction
  endclass

endpackage

// ----- verif/tb_top.sv -----
// Top of the 3x3 strict local maximum sum testbench: clock, reset, APB set-up,
// sample and result traffic with random idling. Depends on lms3_pkg,
// lms3_peak_tracker_pkg and the local_maxima_sum_3x3 RTL.
`timescale 1ns / 1ps
module tb_top;
  import lms3_pkg::*;
  import lms3_peak_tracker_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 80;
  localparam int RANDOM_ITEMS  = 900;
  localparam int RANDOM_TOTALS = 40;

  typedef enum int unsigned {MIX_FULL, MIX_NARROW, MIX_EXTREME} sample_mix_t;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       psel     = 1'b0;
  logic                       penable  = 1'b0;
  logic                       pwrite   = 1'b0;
  logic [ADDR_BITS-1:0]       paddr    = '0;
  logic [DATA_BITS-1:0]       pwdata   = '0;
  logic [DATA_BITS-1:0]       prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  pix_t                       sample   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SUM_BITS-1:0] maxima_sum;
  logic [COUNT_BITS-1:0]      maxima_count;

  local_peak_tracker tracker = new();

  bit          bursty        = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned burst_left    = 0;
  int unsigned samples_sent  = 0;
  int unsigned idle_cycles   = 0;

  always #5 clk = ~clk;

  local_maxima_sum_3x3 DUT (.*);

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tracker.take_sample(sample);
    if (!rst && out_valid && out_ready) tracker.match_total(maxima_sum, maxima_count);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int unsigned phase_left;
    int unsigned stall_pct;
    phase_left = 0;
    stall_pct  = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(16, 160);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 70;
            default: stall_pct = 95;
          endcase
        end
        phase_left--;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic pix_t pick_sample(sample_mix_t mix);
    case (mix)
      MIX_NARROW: return pix_t'(int'($urandom_range(0, 6)) - 3);
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          default: return pix_t'($urandom);
        endcase
      end
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input pix_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = bursty ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic send_block(input int unsigned count, input sample_mix_t mix);
    repeat (count) send_sample(pick_sample(mix));
  endtask

  // hold input until every frame total is back and the pipeline is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.totals_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(4 * int'(idx));
    pwdata  <= DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_register(idx, DATA_BITS'(value));
  endtask

  task automatic set_frame(input int unsigned rows, input int unsigned cols);
    settle();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
  endtask

  initial begin : stimulus
    int unsigned rows;
    int unsigned cols;
    int unsigned frame_len;
    int unsigned target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_frame(1, 1);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    set_frame(0, 0);
    send_sample(16'sd0);
    set_frame(3, 3);
    repeat (9) send_sample(16'sd5);
    set_frame(2, 2);
    send_sample(-16'sd1);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sd1);
    set_frame(2, 3);
    send_block(3, MIX_FULL);
    settle();
    write_reg(REG_COL_COUNT, 3);
    send_block(6, MIX_FULL);

    bursty = 1'b0;
    set_frame(2, 512);
    send_block(1024, MIX_FULL);
    set_frame(1, 1023);
    send_block(512, MIX_NARROW);
    bursty = 1'b1;
    set_frame(65535, 1);
    send_block(65535, MIX_FULL);

    // fill the block behind a stalled receiver
    set_frame(1, 1);
    bursty        = 1'b0;
    long_hold_req = 1'b1;
    send_block(60, MIX_FULL);

    target = samples_sent + RANDOM_ITEMS;
    while (samples_sent < target || tracker.totals_seen < RANDOM_TOTALS) begin
      rows = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
      cols = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
      set_frame(rows, cols);
      bursty    = ($urandom_range(0, 3) != 0);
      frame_len = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols);
      repeat ($urandom_range(1, 4))
        send_block(frame_len, sample_mix_t'($urandom_range(0, 2)));
      // leave a frame unfinished for the next register write to abandon
      if (frame_len > 1 && $urandom_range(0, 5) == 0)
        send_block($urandom_range(1, frame_len - 1), sample_mix_t'($urandom_range(0, 2)));
    end

    settle();
    if (tracker.errors == 0 && tracker.totals_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      if (tracker.totals_due.size() != 0)
        $display("%0t: %0d frame totals never arrived", $time, tracker.totals_due.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lms3_pkg.sv
hw/rtl/local_maxima_sum_3x3.sv
hw/rtl/lms3_checker.sv
verif/lms3_peak_tracker_pkg.sv
verif/tb_top.sv
